/* hw/rtl/ess_pkg.sv */
// Package: shared constants, types and helpers of the elevator stop scheduler.
package ess_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_FLOOR   = 999;
   localparam int FLOOR_W     = 10;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int FIFO_DEPTH  = 2;

   localparam logic [FLOOR_W-1:0] MAX_FLOOR_V = FLOOR_W'(MAX_FLOOR);

   localparam logic CSR_TOP_FLOOR   = 1'b0;
   localparam logic CSR_START_FLOOR = 1'b1;

   typedef enum logic [2:0] {
      EV_QUEUED    = 3'd0,
      EV_DUPLICATE = 3'd1,
      EV_AT_CAR    = 3'd2,
      EV_MOVED     = 3'd3,
      EV_ARRIVED   = 3'd4,
      EV_IDLE      = 3'd5,
      EV_RANGE     = 3'd6,
      EV_FULL      = 3'd7
   } event_type;

   localparam logic [1:0] DIR_IDLE = 2'b00;
   localparam logic [1:0] DIR_UP   = 2'b01;
   localparam logic [1:0] DIR_DOWN = 2'b11;

   // classified word handed from front to back
   typedef struct packed {
      logic               tick;
      logic [FLOOR_W-1:0] floor;
      logic [1:0]         dir;
      logic               bad;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DUP,
      ST_SCAN,
      ST_SHIFT,
      ST_ARRIVE,
      ST_OUT
   } state_type;

   // sign of a direction code: +1, 0, -1 as 2-bit signed
   function automatic logic signed [1:0] dsign(input logic [1:0] d);
      dsign = (d == DIR_IDLE) ? 2'sd0 : (d == DIR_UP) ? 2'sd1 : -2'sd1;
   endfunction

   // f * a compared with f * b: returns -1,0,1 of f*(a-b)
   function automatic logic signed [1:0] fcmp(input logic [1:0] f,
                                               input logic [FLOOR_W-1:0] a,
                                               input logic [FLOOR_W-1:0] b);
      logic signed [1:0] s;
      s = (a > b) ? 2'sd1 : (a < b) ? -2'sd1 : 2'sd0;
      if (f == DIR_IDLE)     fcmp = 2'sd0;
      else if (f == DIR_UP) fcmp = s;
      else                  fcmp = -s;
   endfunction

   function automatic logic signed [1:0] smul(input logic signed [1:0] a,
                                               input logic signed [1:0] b);
      logic signed [3:0] p;
      p = 4'(a) * 4'(b);
      smul = p[1:0];
   endfunction

endpackage

/* hw/rtl/ess_front.sv */
// Front end: accepts request words, normalizes direction, range-checks, queues.
module ess_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,
   input  logic [ess_pkg::FLOOR_W-1:0] top_floor,
   output logic                        cmd_valid,
   input  logic                        cmd_ready,
   output ess_pkg::cmd_type            cmd_word
);
   import ess_pkg::*;

   cmd_type                  fifo_mem [FIFO_DEPTH];
   logic [0:0]               wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]               cnt_ff, cnt_in;
   cmd_type                  cls;
   logic [FLOOR_W-1:0]       top_lim;
   logic                     push, pop;

   assign top_lim = (top_floor < MAX_FLOOR_V) ? top_floor : MAX_FLOOR_V;

   always_comb begin
      cls.tick  = req_tdata[0];
      cls.floor = req_tdata[FLOOR_W:1];
      case (req_tdata[FLOOR_W+2:FLOOR_W+1])
         2'b00:   cls.dir = DIR_IDLE;
         2'b01:   cls.dir = DIR_UP;
         default: cls.dir = DIR_DOWN;
      endcase
      cls.bad = (cls.floor == '0) || (cls.floor > top_lim);
   end

   assign req_tready = (cnt_ff != 2'(FIFO_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd_word   = fifo_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* hw/rtl/ess_back.sv */
// Back end: stop queue, SCAN insertion sequencer, car motion and result register.
module ess_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  ess_pkg::cmd_type            cmd_word,
   input  logic                        start_wr,
   input  logic [ess_pkg::FLOOR_W-1:0] start_value,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata
);
   import ess_pkg::*;

   logic [FLOOR_W-1:0]  qf_ff [QUEUE_DEPTH];
   logic [1:0]          qd_ff [QUEUE_DEPTH];
   logic [FLOOR_W-1:0]  qf_in [QUEUE_DEPTH];
   logic [1:0]          qd_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [FLOOR_W-1:0]  cur_ff, cur_in;
   logic [1:0]          mot_ff, mot_in;
   state_type           st_ff, st_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CNT_W-1:0]    p_ff, p_in;
   logic [1:0]          ph_ff, ph_in;
   logic [1:0]          mode_ff, mode_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [2:0]          ev_ff, ev_in;
   logic                ov_ff, ov_in;
   logic [39:0]         od_ff, od_in;
   logic [IDX_W-1:0]    pi;
   logic [FLOOR_W-1:0]  fl;
   logic signed [1:0]   f, d, dr, fd, drf;
   logic signed [1:0]   c_fc, c_fx;
   logic                at_end, adv;
   logic [FLOOR_W-1:0]  start_cl;

   assign start_cl = (start_value == '0) ? FLOOR_W'(1) :
                     (start_value > MAX_FLOOR_V) ? MAX_FLOOR_V : start_value;
   assign pi     = p_ff[IDX_W-1:0];
   assign fl     = qf_ff[pi];
   assign f      = dsign(mot_ff);
   assign d      = dsign(cmd_ff.dir);
   assign dr     = dsign(qd_ff[pi]);
   assign fd     = smul(d, f);
   assign drf    = smul(dr, f);
   assign c_fc   = fcmp(mot_ff, fl, cur_ff);
   assign c_fx   = fcmp(mot_ff, fl, cmd_ff.floor);
   assign at_end = (p_ff >= len_ff);
   assign cmd_ready = (st_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   always_comb begin
      st_in   = st_ff;
      cmd_in  = cmd_ff;
      p_in    = p_ff;
      ph_in   = ph_ff;
      mode_in = mode_ff;
      rem_in  = rem_ff;
      ev_in   = ev_ff;
      len_in  = len_ff;
      cur_in  = cur_ff;
      mot_in  = mot_ff;
      ov_in   = ov_ff;
      od_in   = od_ff;
      adv     = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         qf_in[i] = qf_ff[i];
         qd_in[i] = qd_ff[i];
      end
      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end
      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_word;
               p_in   = '0;
               ph_in  = '0;
               rem_in = '0;
               if (cmd_word.tick) begin
                  if (len_ff == '0) begin
                     mot_in = DIR_IDLE;
                     ev_in  = EV_IDLE;
                     st_in  = ST_OUT;
                  end else if (cur_ff == qf_ff[0]) begin
                     st_in = ST_ARRIVE;
                  end else begin
                     if (cur_ff > qf_ff[0]) begin
                        mot_in = DIR_DOWN;
                        cur_in = cur_ff - 1'b1;
                     end else begin
                        mot_in = DIR_UP;
                        cur_in = cur_ff + 1'b1;
                     end
                     ev_in = EV_MOVED;
                     st_in = ST_OUT;
                  end
               end else if (cmd_word.bad) begin
                  ev_in = EV_RANGE;
                  st_in = ST_OUT;
               end else if (cmd_word.floor == cur_ff) begin
                  ev_in = EV_AT_CAR;
                  st_in = ST_OUT;
               end else begin
                  st_in = ST_DUP;
               end
            end
         end
         ST_DUP: begin
            if (at_end) begin
               p_in = '0;
               if (len_ff == CNT_W'(QUEUE_DEPTH)) begin
                  ev_in = EV_FULL;
                  st_in = ST_OUT;
               end else begin
                  if (f * (cmd_ff.floor > cur_ff ? 1 : -1) > 0 && fd >= 0) mode_in = 2'd0;
                  else if (fd <= 0) mode_in = 2'd1;
                  else              mode_in = 2'd2;
                  st_in = ST_SCAN;
               end
            end else if (fl == cmd_ff.floor) begin
               if (qd_ff[pi] == cmd_ff.dir) begin
                  ev_in = EV_DUPLICATE;
                  st_in = ST_OUT;
               end else if (len_ff == CNT_W'(QUEUE_DEPTH)) begin
                  ev_in = EV_FULL;
                  st_in = ST_OUT;
               end else if (fd < 0) begin
                  p_in  = p_ff + 1'b1;
                  st_in = ST_SHIFT;
               end else begin
                  p_in = '0;
                  if (f * (cmd_ff.floor > cur_ff ? 1 : -1) > 0 && fd >= 0) mode_in = 2'd0;
                  else if (fd <= 0) mode_in = 2'd1;
                  else              mode_in = 2'd2;
                  st_in = ST_SCAN;
               end
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            // one queue entry tested per cycle; phase steps when a loop stops
            if (at_end) begin
               st_in = ST_SHIFT;
            end else begin
               case (ph_ff)
                  2'd0: begin
                     if (mode_ff == 2'd0)
                        adv = (c_fc >= 0) && (c_fx < 0) && (drf >= 0);
                     else
                        adv = (c_fc >= 0) && (drf >= 0);
                  end
                  2'd1: begin
                     if (mode_ff == 2'd1) adv = (drf <= 0) && (c_fx > 0);
                     else                 adv = (drf <= 0);
                  end
                  default: adv = (drf >= 0) && (c_fx < 0);
               endcase
               if (adv) begin
                  p_in = p_ff + 1'b1;
               end else if (mode_ff == 2'd0 || ph_ff == mode_ff) begin
                  st_in = ST_SHIFT;
               end else begin
                  ph_in = ph_ff + 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (CNT_W'(i) == p_ff) begin
                  qf_in[i] = cmd_ff.floor;
                  qd_in[i] = cmd_ff.dir;
               end
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
               if (CNT_W'(i) > p_ff && CNT_W'(i) <= len_ff) begin
                  qf_in[i] = qf_ff[i-1];
                  qd_in[i] = qd_ff[i-1];
               end
            end
            len_in = len_ff + 1'b1;
            ev_in  = EV_QUEUED;
            st_in  = ST_OUT;
         end
         ST_ARRIVE: begin
            // pop one head stop per cycle while it matches the car floor
            if (len_ff != '0 && qf_ff[0] == cur_ff) begin
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  qf_in[i] = qf_ff[i+1];
                  qd_in[i] = qd_ff[i+1];
               end
               len_in = len_ff - 1'b1;
               rem_in = rem_ff + 1'b1;
            end else begin
               if (len_ff == '0)          mot_in = DIR_IDLE;
               else if (cur_ff > qf_ff[0]) mot_in = DIR_DOWN;
               else                       mot_in = DIR_UP;
               ev_in = EV_ARRIVED;
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               od_in = {5'b0, rem_ff, len_ff, (len_ff != '0) ? qf_ff[0] : '0,
                        mot_ff, cur_ff, ev_ff};
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (start_wr) begin
         cur_in = start_cl;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         qf_ff[i] <= qf_in[i];
         qd_ff[i] <= qd_in[i];
      end
      cmd_ff  <= cmd_in;
      p_ff    <= p_in;
      ph_ff   <= ph_in;
      mode_ff <= mode_in;
      rem_ff  <= rem_in;
      ev_ff   <= ev_in;
      od_ff   <= od_in;
      if (reset) begin
         st_ff  <= ST_IDLE;
         len_ff <= '0;
         cur_ff <= FLOOR_W'(1);
         mot_ff <= DIR_IDLE;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         len_ff <= len_in;
         cur_ff <= cur_in;
         mot_ff <= mot_in;
         ov_ff  <= ov_in;
      end
   end

endmodule

/* hw/rtl/elevator_stop_scheduler.sv */
// Top level: elevator stop scheduler, front classifier plus back sequencer.
// Usage:
//   req_ channel takes one word per call or tick; rsp_ returns one word per
//   request word, in order. csr_ writes top_floor (index 0) and start_floor
//   (index 1); a start_floor write moves the car at once (clamped).
// Sequencing: a tick goes straight to the output step, or through the arrive step
//   when the car is at the head stop; a call rejected early goes straight to
//   output, and a queued call is handled by the back sequencer that walks the
//   16-entry stop queue one entry per cycle (duplicate search, then SCAN slot
//   search).
// Throughput: one word in the back end at a time; a 2-word queue between the
//   front and back lets requests be taken while the back end is busy.
// Reset: queue empty, car at floor 1, idle, top_floor 999.
// Stall: a held result stays in the output register; the back end waits in
//   its output step, and the request queue fills and deasserts req_tready.
module elevator_stop_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // func[0], call_floor[10:1], call_direction[12:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // event_res[2:0], car_floor[12:3],
                                    // travel_direction[14:13], next_stop[24:15],
                                    // pending_count[29:25], removed_count[34:30]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);
   import ess_pkg::*;

   logic [FLOOR_W-1:0] top_ff;
   logic               cmd_valid, cmd_ready;
   cmd_type            cmd_word;
   logic               start_wr;

   assign csr_ready = 1'b1;
   assign start_wr  = csr_valid && (csr_index == CSR_START_FLOOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= MAX_FLOOR_V;
      end else if (csr_valid && csr_index == CSR_TOP_FLOOR) begin
         top_ff <= csr_data;
      end
   end

   ess_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .top_floor(top_ff), .cmd_valid, .cmd_ready, .cmd_word
   );

   ess_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_word,
      .start_wr, .start_value(csr_data),
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule

/* hw/rtl/ess_checker.sv */
// Checker: port-level properties of the elevator stop scheduler, bound to the top.
module ess_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import ess_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:25] <= 5'd16)
      else $error("pending count over depth");
   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29:25] == 5'd0 |-> rsp_tdata[24:15] == 10'd0)
      else $error("next stop on empty queue");
   a_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != EV_ARRIVED |-> rsp_tdata[34:30] == 5'd0)
      else $error("removed count outside arrival");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind elevator_stop_scheduler ess_checker u_ess_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

/* sim/tb_elevator_stop_scheduler.sv */
// Testbench: elevator stop scheduler checked word by word against a SCAN queue predictor.
module tb_elevator_stop_scheduler;
   import ess_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [4:0] removed;
      logic [4:0] pend;
      logic [9:0] head;
      logic [1:0] dir;
      logic [9:0] car;
      logic [2:0] ev;
   } status_type;

   typedef struct {
      logic       tick;
      logic [9:0] floor;
      logic [1:0] dir;
      logic       has_status;
      logic [2:0] ev;
      logic [9:0] car;
      logic [4:0] pend;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = 0;
   logic [9:0]  csr_data = '0;

   elevator_stop_scheduler u_top (.*);

   initial forever #4 clock = ~clock;

   // predictor state
   int         stop_floor[QUEUE_DEPTH];
   int         stop_dir[QUEUE_DEPTH];
   int         stop_count;
   int         car_at;
   int         motion;
   int         top_limit;

   status_type status_fifo[$];
   int         errors = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   bit         hold_off = 0;
   int         words_in = 0;
   int         words_out = 0;
   int         quiet_cycles = 0;

   function automatic int dir_value(logic [1:0] d);
      return d == DIR_IDLE ? 0 : (d == DIR_UP ? 1 : -1);
   endfunction

   function automatic int scan_position(int x, int d);
      int f, p, n;
      f = motion;
      p = 0;
      n = stop_count;
      if (f * (x - car_at) > 0 && d * f >= 0) begin
         while (p < n && f * stop_floor[p] >= f * car_at && f * stop_floor[p] < f * x
                && f * stop_dir[p] >= 0) p++;
      end else if (d * f <= 0) begin
         while (p < n && f * stop_floor[p] >= f * car_at && f * stop_dir[p] >= 0) p++;
         while (p < n && stop_dir[p] * f <= 0 && f * stop_floor[p] > f * x) p++;
      end else begin
         while (p < n && f * stop_floor[p] >= f * car_at && f * stop_dir[p] >= 0) p++;
         while (p < n && stop_dir[p] * f <= 0) p++;
         while (p < n && stop_dir[p] * f >= 0 && f * x > f * stop_floor[p]) p++;
      end
      return p;
   endfunction

   function automatic event_type place_call(int x, int d);
      int slot;
      bit fixed_slot;
      slot = 0;
      fixed_slot = 0;
      if (x < 1 || x > top_limit) return EV_RANGE;
      if (x == car_at) return EV_AT_CAR;
      for (int i = 0; i < stop_count; i++) begin
         if (stop_floor[i] == x) begin
            if (stop_dir[i] == d) return EV_DUPLICATE;
            if (motion * d < 0) begin
               slot = i + 1;
               fixed_slot = 1;
            end
            break;
         end
      end
      if (stop_count >= QUEUE_DEPTH) return EV_FULL;
      if (!fixed_slot) slot = scan_position(x, d);
      for (int i = stop_count; i > slot; i--) begin
         stop_floor[i] = stop_floor[i-1];
         stop_dir[i] = stop_dir[i-1];
      end
      stop_floor[slot] = x;
      stop_dir[slot] = d;
      stop_count++;
      return EV_QUEUED;
   endfunction

   function automatic status_type advance_car(logic tick, logic [9:0] floor, logic [1:0] dir);
      status_type s;
      int k;
      k = 0;
      if (!tick) s.ev = place_call(int'(floor), dir_value(dir));
      else if (stop_count == 0) begin
         motion = 0;
         s.ev = EV_IDLE;
      end else if (car_at == stop_floor[0]) begin
         while (k < stop_count && stop_floor[k] == car_at) k++;
         for (int i = k; i < stop_count; i++) begin
            stop_floor[i-k] = stop_floor[i];
            stop_dir[i-k] = stop_dir[i];
         end
         stop_count -= k;
         motion = stop_count == 0 ? 0 : (car_at > stop_floor[0] ? -1 : 1);
         s.ev = EV_ARRIVED;
      end else begin
         motion = car_at > stop_floor[0] ? -1 : 1;
         car_at += motion;
         s.ev = EV_MOVED;
      end
      s.car = 10'(car_at);
      s.dir = 2'(motion);
      s.head = stop_count != 0 ? 10'(stop_floor[0]) : '0;
      s.pend = 5'(stop_count);
      s.removed = 5'(k);
      return s;
   endfunction

   task automatic write_csr(logic idx, logic [9:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_TOP_FLOOR) top_limit = value < MAX_FLOOR ? int'(value) : MAX_FLOOR;
      else car_at = value < 1 ? 1 : (value > MAX_FLOOR ? MAX_FLOOR : int'(value));
      @(posedge clock);
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 0;
      while (status_fifo.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send_word(logic tick, logic [9:0] floor, logic [1:0] dir);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b0, dir, floor, tick};
      do @(posedge clock); while (!req_tready);
      status_fifo.push_back(advance_car(tick, floor, dir));
      words_in++;
   endtask

   function automatic logic [1:0] random_dir();
      return 2'($urandom_range(3));
   endfunction

   task automatic random_words(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 45) send_word(1, 10'($urandom), random_dir());
         else if (r < 90) send_word(0, 10'($urandom_range(1, 40)), random_dir());
         else if (r < 95) send_word(0, 10'($urandom), random_dir());
         else send_word(0, $urandom_range(1) ? 10'd0 : 10'h3ff, random_dir());
      end
   endtask

   // receiver side and checking
   always @(posedge clock) begin
      status_type got, want;
      if (reset) rsp_tready <= 0;
      else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[34:0];
            words_out++;
            if (status_fifo.size() == 0) begin
               $error("unexpected word %h", rsp_tdata);
               errors++;
            end else begin
               want = status_fifo.pop_front();
               if (got.ev != want.ev) begin
                  $error("event_res exp %0d got %0d", want.ev, got.ev); errors++;
               end
               if (got.car != want.car) begin
                  $error("car_floor exp %0d got %0d", want.car, got.car); errors++;
               end
               if (got.dir != want.dir) begin
                  $error("travel_direction exp %0d got %0d", want.dir, got.dir); errors++;
               end
               if (got.head != want.head) begin
                  $error("next_stop exp %0d got %0d", want.head, got.head); errors++;
               end
               if (got.pend != want.pend) begin
                  $error("pending_count exp %0d got %0d", want.pend, got.pend); errors++;
               end
               if (got.removed != want.removed) begin
                  $error("removed_count exp %0d got %0d", want.removed, got.removed);
                  errors++;
               end
            end
         end
         rsp_tready <= !hold_off && !(recv_stall_pct != 0
                                      && $urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress, %0d words outstanding", status_fifo.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   row_type directed[] = '{
      '{1, 10'd0,   DIR_IDLE, 1, EV_IDLE,   10'd1, 5'd0},
      '{0, 10'd1,   DIR_UP,   1, EV_AT_CAR, 10'd1, 5'd0},
      '{0, 10'd0,   DIR_UP,   1, EV_RANGE,  10'd1, 5'd0},
      '{0, 10'h3ff, DIR_DOWN, 1, EV_RANGE,  10'd1, 5'd0},
      '{0, 10'd9,   DIR_DOWN, 1, EV_QUEUED, 10'd1, 5'd1},
      '{0, 10'd9,   DIR_DOWN, 1, EV_DUPLICATE, 10'd1, 5'd1},
      '{0, 10'd9,   2'b10,    1, EV_DUPLICATE, 10'd1, 5'd1},
      '{0, 10'd5,   DIR_UP,   0, 0, 0, 0},
      '{0, 10'd3,   DIR_IDLE, 0, 0, 0, 0},
      '{1, 10'd0,   DIR_IDLE, 0, 0, 0, 0},
      '{0, 10'd5,   DIR_DOWN, 0, 0, 0, 0},
      '{0, 10'd4,   DIR_DOWN, 0, 0, 0, 0},
      '{0, 10'd2,   DIR_UP,   0, 0, 0, 0},
      '{1, 10'd0,   DIR_IDLE, 0, 0, 0, 0},
      '{1, 10'h3ff, DIR_UP,   0, 0, 0, 0},
      '{1, 10'd0,   DIR_IDLE, 0, 0, 0, 0},
      '{1, 10'd0,   DIR_IDLE, 0, 0, 0, 0},
      '{1, 10'd0,   DIR_IDLE, 0, 0, 0, 0},
      '{1, 10'd0,   DIR_IDLE, 0, 0, 0, 0},
      '{1, 10'd0,   DIR_IDLE, 0, 0, 0, 0}
   };

   initial begin
      status_type want;
      stop_count = 0;
      motion = 0;
      car_at = 1;
      top_limit = MAX_FLOOR;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].has_status) begin
            want = advance_car(directed[i].tick, directed[i].floor, directed[i].dir);
            if (want.ev != directed[i].ev || want.car != directed[i].car
                || want.pend != directed[i].pend) begin
               $error("directed row %0d: table and predictor disagree", i);
               errors++;
            end
            // undo: the table row is replayed through send_word
         end
      end
      // replay from reset state for the actual run
      stop_count = 0; motion = 0; car_at = 1; top_limit = MAX_FLOOR;
      foreach (directed[i]) send_word(directed[i].tick, directed[i].floor, directed[i].dir);

      // fill the queue to its limit and past it, then an out-of-range and a full-queue call
      drain_and_settle();
      write_csr(CSR_TOP_FLOOR, 10'd40);
      for (int f = 20; f <= 37; f++) send_word(0, 10'(f), DIR_IDLE);
      send_word(0, 10'd41, DIR_UP);
      send_word(0, 10'd40, DIR_UP);
      while (stop_count != 0) send_word(1, '0, DIR_IDLE);

      // random phases under different idling
      for (int ph = 0; ph < 4; ph++) begin
         drain_and_settle();
         case (ph)
            0: begin
               write_csr(CSR_TOP_FLOOR, 10'd1);
               write_csr(CSR_START_FLOOR, 10'd0);
               send_idle_pct = 0; recv_stall_pct = 0;
               random_words(30);
               drain_and_settle();
               write_csr(CSR_TOP_FLOOR, 10'd1023);
               write_csr(CSR_START_FLOOR, 10'd999);
               random_words(20);
               drain_and_settle();
               write_csr(CSR_START_FLOOR, 10'd1023);
               write_csr(CSR_TOP_FLOOR, 10'd32);
               random_words(150);
            end
            1: begin
               write_csr(CSR_START_FLOOR, 10'd20);
               write_csr(CSR_TOP_FLOOR, 10'd40);
               send_idle_pct = 80; recv_stall_pct = 0;
               random_words(200);
            end
            2: begin
               write_csr(CSR_TOP_FLOOR, 10'd25);
               send_idle_pct = 0; recv_stall_pct = 80;
               random_words(200);
            end
            default: begin
               write_csr(CSR_TOP_FLOOR, 10'd999);
               write_csr(CSR_START_FLOOR, 10'd10);
               send_idle_pct = 25; recv_stall_pct = 25;
               random_words(150);
            end
         endcase
      end

      // long receiver hold-off while the sender keeps offering words
      drain_and_settle();
      send_idle_pct = 0; recv_stall_pct = 0;
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         random_words(40);
      join

      drain_and_settle();
      $display("covered %0d request words, %0d checked responses", words_in, words_out);
      $display("phases: directed, queue fill, four idle mixes, response hold-off");
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
